>>> design/goal_approach_velocity_shaper_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the goal approach velocity shaper
// Same-cycle-implication and next-cycle-implication property wrappers.
// ----------------------------------------------------------------------------
`ifndef GOAL_APPROACH_VELOCITY_SHAPER_ASSERT_SVH
`define GOAL_APPROACH_VELOCITY_SHAPER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define GAVS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define GAVS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/gavs_pkg.sv
// ----------------------------------------------------------------------------
// gavs_pkg
// Shared types, constants and the arctangent table of the velocity shaper.
// ----------------------------------------------------------------------------
package gavs_pkg;

  localparam int unsigned CordicSteps = 24;
  localparam int unsigned SqrtSteps   = 32;
  localparam int unsigned DivSteps    = 32;
  localparam int unsigned DivLanes    = 3;

  // Inverse CORDIC gain in Q0.31.
  localparam logic [30:0] InvGainQ31 = 31'd1304065748;

  // Register reset values.
  localparam logic [30:0] ApproachRadiusRst = 31'd98304;
  localparam logic [30:0] SpeedLimitRst     = 31'd32768;
  localparam logic [30:0] DirectRadiusRst   = 31'd32768;
  localparam logic [23:0] DirectGainRst     = 24'd65536;
  localparam logic [30:0] StopRadiusRst     = 31'd16384;

  typedef enum logic [2:0] {
    ZONE_BYPASS  = 3'd0,
    ZONE_GOAL    = 3'd1,
    ZONE_DIRECT  = 3'd2,
    ZONE_LIMITED = 3'd3,
    ZONE_FAR     = 3'd4
  } zone_e;

  typedef enum logic [2:0] {
    REG_ACTIVE          = 3'd0,
    REG_GOAL_X          = 3'd1,
    REG_GOAL_Y          = 3'd2,
    REG_APPROACH_RADIUS = 3'd3,
    REG_SPEED_LIMIT     = 3'd4,
    REG_DIRECT_RADIUS   = 3'd5,
    REG_DIRECT_GAIN     = 3'd6,
    REG_STOP_RADIUS     = 3'd7
  } reg_e;

  // Everything one item carries down the chain.
  typedef struct packed {
    logic [31:0]              vx;
    logic [31:0]              vy;
    logic [31:0]              wz;
    logic [15:0]              yaw;
    zone_e                    zone;
    logic                     huge;
    logic                     lim;
    logic                     flip;
    logic [30:0]              adx;
    logic [30:0]              ady;
    logic [63:0]              d2a;
    logic [63:0]              d2b;
    logic [63:0]              v2a;
    logic [63:0]              v2b;
    logic signed [35:0]       bx;
    logic signed [35:0]       by;
    logic [31:0]              bz;
    logic [63:0]              sq_n;
    logic [33:0]              sq_rem;
    logic [31:0]              sq_root;
    logic [39:0]              tgt;
    logic signed [33:0]       rx;
    logic signed [33:0]       ry;
    logic signed [32:0]       rz;
    logic [2:0]               dv_neg;
    logic [2:0][31:0]         dv_rem;
    logic [2:0][31:0]         dv_q;
  } pipe_t;

  // Arctangent of 2^-step as a 32-bit binary angle.
  function automatic logic [31:0] atan_angle(input logic [4:0] step);
    logic [31:0] a;
    case (step)
      5'd0:    a = 32'h20000000;
      5'd1:    a = 32'h12E4051E;
      5'd2:    a = 32'h09FB385B;
      5'd3:    a = 32'h051111D4;
      5'd4:    a = 32'h028B0D43;
      5'd5:    a = 32'h0145D7E1;
      5'd6:    a = 32'h00A2F61E;
      5'd7:    a = 32'h00517C55;
      5'd8:    a = 32'h0028BE53;
      5'd9:    a = 32'h00145F2F;
      5'd10:   a = 32'h000A2F98;
      5'd11:   a = 32'h000517CC;
      5'd12:   a = 32'h00028BE6;
      5'd13:   a = 32'h000145F3;
      5'd14:   a = 32'h0000A2FA;
      5'd15:   a = 32'h0000517D;
      5'd16:   a = 32'h000028BE;
      5'd17:   a = 32'h0000145F;
      5'd18:   a = 32'h00000A30;
      5'd19:   a = 32'h00000518;
      5'd20:   a = 32'h0000028C;
      5'd21:   a = 32'h00000146;
      5'd22:   a = 32'h000000A3;
      5'd23:   a = 32'h00000051;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

endpackage

>>> design/gavs_vec_cell.sv
// ----------------------------------------------------------------------------
// gavs_vec_cell
// One CORDIC vectoring step that accumulates the bearing to the goal.
// ----------------------------------------------------------------------------
module gavs_vec_cell import gavs_pkg::*; #(
  parameter int unsigned STEP = 0
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  valid_i,
  input  pipe_t data_i,
  output logic  valid_o,
  output pipe_t data_o
);

  logic  valid_q;
  pipe_t data_q;
  pipe_t data_d;
  logic signed [35:0] xs;
  logic signed [35:0] ys;

  // Drive y toward zero and add up the turned angle.
  always_comb begin
    data_d = data_i;
    xs = $signed(data_i.bx) >>> STEP;
    ys = $signed(data_i.by) >>> STEP;
    if (!data_i.by[35]) begin
      data_d.bx = data_i.bx + ys;
      data_d.by = data_i.by - xs;
      data_d.bz = data_i.bz + atan_angle(5'(STEP));
    end else begin
      data_d.bx = data_i.bx - ys;
      data_d.by = data_i.by + xs;
      data_d.bz = data_i.bz - atan_angle(5'(STEP));
    end
  end

  // Stage valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // Stage payload.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> design/gavs_sqrt_cell.sv
// ----------------------------------------------------------------------------
// gavs_sqrt_cell
// One digit step of the integer square root; settles one root bit.
// ----------------------------------------------------------------------------
module gavs_sqrt_cell import gavs_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  valid_i,
  input  pipe_t data_i,
  output logic  valid_o,
  output pipe_t data_o
);

  logic  valid_q;
  pipe_t data_q;
  pipe_t data_d;
  logic [35:0] wide;
  logic [35:0] trial;

  // Bring down two operand bits and try the next root bit.
  always_comb begin
    data_d = data_i;
    wide   = {data_i.sq_rem, data_i.sq_n[63:62]};
    trial  = {2'b00, data_i.sq_root, 2'b01};
    data_d.sq_n = {data_i.sq_n[61:0], 2'b00};
    if (wide >= trial) begin
      data_d.sq_rem  = 34'(wide - trial);
      data_d.sq_root = {data_i.sq_root[30:0], 1'b1};
    end else begin
      data_d.sq_rem  = wide[33:0];
      data_d.sq_root = {data_i.sq_root[30:0], 1'b0};
    end
  end

  // Stage valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // Stage payload.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> design/gavs_rot_cell.sv
// ----------------------------------------------------------------------------
// gavs_rot_cell
// One CORDIC rotation step that turns the target speed onto the heading.
// ----------------------------------------------------------------------------
module gavs_rot_cell import gavs_pkg::*; #(
  parameter int unsigned STEP = 0
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  valid_i,
  input  pipe_t data_i,
  output logic  valid_o,
  output pipe_t data_o
);

  logic  valid_q;
  pipe_t data_q;
  pipe_t data_d;
  logic signed [33:0] xs;
  logic signed [33:0] ys;

  // Rotate toward a residual angle of zero.
  always_comb begin
    data_d = data_i;
    xs = $signed(data_i.rx) >>> STEP;
    ys = $signed(data_i.ry) >>> STEP;
    if (!data_i.rz[32]) begin
      data_d.rx = data_i.rx - ys;
      data_d.ry = data_i.ry + xs;
      data_d.rz = data_i.rz - $signed({1'b0, atan_angle(5'(STEP))});
    end else begin
      data_d.rx = data_i.rx + ys;
      data_d.ry = data_i.ry - xs;
      data_d.rz = data_i.rz + $signed({1'b0, atan_angle(5'(STEP))});
    end
  end

  // Stage valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // Stage payload.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> design/gavs_div_cell.sv
// ----------------------------------------------------------------------------
// gavs_div_cell
// One restoring division step, settling one quotient bit in each lane.
// ----------------------------------------------------------------------------
module gavs_div_cell import gavs_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  valid_i,
  input  pipe_t data_i,
  output logic  valid_o,
  output pipe_t data_o
);

  logic  valid_q;
  pipe_t data_q;
  pipe_t data_d;
  logic [DivLanes-1:0][32:0] wide;
  logic [32:0] den;

  // The divisor is the root held from the root stage: the measured planar speed outside the direct zone.
  always_comb begin
    data_d = data_i;
    den    = {1'b0, data_i.sq_root};
    for (int i = 0; i < DivLanes; i++) begin
      wide[i] = {data_i.dv_rem[i], data_i.dv_q[i][31]};
      if (wide[i] >= den) begin
        data_d.dv_rem[i] = 32'(wide[i] - den);
        data_d.dv_q[i]   = {data_i.dv_q[i][30:0], 1'b1};
      end else begin
        data_d.dv_rem[i] = wide[i][31:0];
        data_d.dv_q[i]   = {data_i.dv_q[i][30:0], 1'b0};
      end
    end
  end

  // Stage valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // Stage payload.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> design/goal_approach_velocity_shaper.sv
// ----------------------------------------------------------------------------
// goal_approach_velocity_shaper
// Shapes a planar velocity command by the robot's distance to a goal.
// ----------------------------------------------------------------------------
// Usage:
// Each input transfer on the s_axis channel carries one command and pose; each
// output transfer on the m_axis channel carries the shaped command and its zone.
// The user must set goal and limits over the APB port only while no item is in flight; the block does not enforce this.
// Every item walks a fixed chain of cells: four setup stages, 24 vectoring
// cells for the bearing, 32 square-root cells, four scaling stages, 24
// rotation cells, 32 division cells and the output register. One item is
// taken every cycle while no result waits at a stalled output; the
// throughput of one item per clock is set by the one-step-per-cell chain.
// When the receiver stalls with a result waiting, the whole chain holds and
// s_axis_tready drops; bubbles in the chain are not squeezed out.
// Reset clears all stage valid bits and loads the register defaults; no
// clearing pass is needed, so the block takes items from the first cycle.
// ----------------------------------------------------------------------------
`include "goal_approach_velocity_shaper_assert.svh"

module goal_approach_velocity_shaper import gavs_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Input stream.
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // cmd_vx, cmd_vy, cmd_wz, pose_x, pose_y, pose_yaw (from bit 0 up)
  input  logic [175:0] s_axis_tdata,
  // pose_valid
  input  logic [0:0]   s_axis_tuser,
  // Output stream.
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_vx, out_vy, out_wz (from bit 0 up)
  output logic [95:0]  m_axis_tdata,
  // zone
  output logic [2:0]   m_axis_tuser,
  // Configuration port.
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic        active_q;
  logic [31:0] goal_x_q;
  logic [31:0] goal_y_q;
  logic [30:0] approach_radius_q;
  logic [30:0] speed_limit_q;
  logic [30:0] direct_radius_q;
  logic [23:0] direct_gain_q;
  logic [30:0] stop_radius_q;
  logic        cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  // Register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q          <= 1'b0;
      goal_x_q          <= '0;
      goal_y_q          <= '0;
      approach_radius_q <= ApproachRadiusRst;
      speed_limit_q     <= SpeedLimitRst;
      direct_radius_q   <= DirectRadiusRst;
      direct_gain_q     <= DirectGainRst;
      stop_radius_q     <= StopRadiusRst;
    end else if (cfg_we) begin
      case (reg_e'(paddr[4:2]))
        REG_ACTIVE:          active_q          <= pwdata[0];
        REG_GOAL_X:          goal_x_q          <= pwdata;
        REG_GOAL_Y:          goal_y_q          <= pwdata;
        REG_APPROACH_RADIUS: approach_radius_q <= pwdata[30:0];
        REG_SPEED_LIMIT:     speed_limit_q     <= pwdata[30:0];
        REG_DIRECT_RADIUS:   direct_radius_q   <= pwdata[30:0];
        REG_DIRECT_GAIN:     direct_gain_q     <= pwdata[23:0];
        REG_STOP_RADIUS:     stop_radius_q     <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  // Register reads.
  always_comb begin
    case (reg_e'(paddr[4:2]))
      REG_ACTIVE:          prdata = {31'd0, active_q};
      REG_GOAL_X:          prdata = goal_x_q;
      REG_GOAL_Y:          prdata = goal_y_q;
      REG_APPROACH_RADIUS: prdata = {1'b0, approach_radius_q};
      REG_SPEED_LIMIT:     prdata = {1'b0, speed_limit_q};
      REG_DIRECT_RADIUS:   prdata = {1'b0, direct_radius_q};
      REG_DIRECT_GAIN:     prdata = {8'd0, direct_gain_q};
      REG_STOP_RADIUS:     prdata = {1'b0, stop_radius_q};
      default:             prdata = '0;
    endcase
  end

  // Squared radii and limit, refreshed every cycle from the registers.
  logic [61:0] stop_sq_q;
  logic [61:0] direct_sq_q;
  logic [61:0] approach_sq_q;
  logic [61:0] limit_sq_q;

  always_ff @(posedge clk_i) begin
    stop_sq_q     <= 62'(stop_radius_q) * 62'(stop_radius_q);
    direct_sq_q   <= 62'(direct_radius_q) * 62'(direct_radius_q);
    approach_sq_q <= 62'(approach_radius_q) * 62'(approach_radius_q);
    limit_sq_q    <= 62'(speed_limit_q) * 62'(speed_limit_q);
  end

  // --------------------------------------------------------------------------
  // Chain advance: everything moves unless a result waits at the output.
  // --------------------------------------------------------------------------
  logic en;
  logic m_valid_q;

  assign en            = !m_valid_q || m_axis_tready;
  assign s_axis_tready = en;

  // --------------------------------------------------------------------------
  // Setup stages
  // --------------------------------------------------------------------------
  pipe_t st1_d, st1_q, st2_d, st2_q, st3_d, st3_q, st4_d, st4_q;
  logic  st1_valid_q, st2_valid_q, st3_valid_q, st4_valid_q;
  logic [32:0] dx;
  logic [32:0] dy;
  logic [35:0] adx;
  logic [35:0] ady;
  logic [63:0] dist_sq;
  logic [63:0] speed_sq;

  // Capture the transfer and form the offset to the goal.
  always_comb begin
    st1_d     = '0;
    dx        = {goal_x_q[31], goal_x_q} - {s_axis_tdata[127], s_axis_tdata[127:96]};
    dy        = {goal_y_q[31], goal_y_q} - {s_axis_tdata[159], s_axis_tdata[159:128]};
    st1_d.vx  = s_axis_tdata[31:0];
    st1_d.vy  = s_axis_tdata[63:32];
    st1_d.wz  = s_axis_tdata[95:64];
    st1_d.yaw = s_axis_tdata[175:160];
    st1_d.zone = (active_q && s_axis_tuser[0]) ? ZONE_FAR : ZONE_BYPASS;
    st1_d.bx  = {{3{dx[32]}}, dx};
    st1_d.by  = {{3{dy[32]}}, dy};
  end

  // Magnitudes, signs and the half-turn start of the bearing search.
  always_comb begin
    st2_d      = st1_q;
    adx        = st1_q.bx[35] ? (36'd0 - st1_q.bx) : st1_q.bx;
    ady        = st1_q.by[35] ? (36'd0 - st1_q.by) : st1_q.by;
    st2_d.huge = (|adx[35:31]) || (|ady[35:31]);
    st2_d.adx  = adx[30:0];
    st2_d.ady  = ady[30:0];
    st2_d.dv_neg = {st1_q.wz[31], st1_q.vy[31], st1_q.vx[31]};
    st2_d.dv_q[0] = st1_q.vx[31] ? (32'd0 - st1_q.vx) : st1_q.vx;
    st2_d.dv_q[1] = st1_q.vy[31] ? (32'd0 - st1_q.vy) : st1_q.vy;
    st2_d.dv_q[2] = st1_q.wz[31] ? (32'd0 - st1_q.wz) : st1_q.wz;
    if (st1_q.bx[35]) begin
      st2_d.bx = 36'd0 - st1_q.bx;
      st2_d.by = 36'd0 - st1_q.by;
      st2_d.bz = 32'h80000000;
    end else begin
      st2_d.bz = 32'h00000000;
    end
  end

  // Squares of the offset and of the command.
  always_comb begin
    st3_d     = st2_q;
    st3_d.d2a = 64'(st2_q.adx) * 64'(st2_q.adx);
    st3_d.d2b = 64'(st2_q.ady) * 64'(st2_q.ady);
    st3_d.v2a = 64'(st2_q.dv_q[0]) * 64'(st2_q.dv_q[0]);
    st3_d.v2b = 64'(st2_q.dv_q[1]) * 64'(st2_q.dv_q[1]);
  end

  // Zone decision and choice of the square-root operand.
  always_comb begin
    st4_d    = st3_q;
    dist_sq  = st3_q.d2a + st3_q.d2b;
    speed_sq = st3_q.v2a + st3_q.v2b;
    if (st3_q.zone == ZONE_FAR && !st3_q.huge) begin
      if (dist_sq <= {2'b00, stop_sq_q}) begin
        st4_d.zone = ZONE_GOAL;
      end else if (dist_sq < {2'b00, direct_sq_q}) begin
        st4_d.zone = ZONE_DIRECT;
      end else if (dist_sq < {2'b00, approach_sq_q}) begin
        st4_d.zone = ZONE_LIMITED;
      end
    end
    st4_d.lim     = (speed_sq > {2'b00, limit_sq_q});
    st4_d.sq_n    = (st4_d.zone == ZONE_DIRECT) ? dist_sq : speed_sq;
    st4_d.sq_rem  = '0;
    st4_d.sq_root = '0;
  end

  // Setup stage registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st1_valid_q <= 1'b0;
      st2_valid_q <= 1'b0;
      st3_valid_q <= 1'b0;
      st4_valid_q <= 1'b0;
    end else if (en) begin
      st1_valid_q <= s_axis_tvalid;
      st2_valid_q <= st1_valid_q;
      st3_valid_q <= st2_valid_q;
      st4_valid_q <= st3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      st1_q <= st1_d;
      st2_q <= st2_d;
      st3_q <= st3_d;
      st4_q <= st4_d;
    end
  end

  // --------------------------------------------------------------------------
  // Bearing cells, then square-root cells
  // --------------------------------------------------------------------------
  pipe_t vec_data  [CordicSteps+1];
  logic  vec_valid [CordicSteps+1];
  pipe_t sq_data   [SqrtSteps+1];
  logic  sq_valid  [SqrtSteps+1];

  assign vec_data[0]  = st4_q;
  assign vec_valid[0] = st4_valid_q;

  for (genvar g = 0; g < CordicSteps; g++) begin : g_vec
    gavs_vec_cell #(.STEP(g)) u_vec (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (vec_valid[g]),
      .data_i  (vec_data[g]),
      .valid_o (vec_valid[g+1]),
      .data_o  (vec_data[g+1])
    );
  end

  assign sq_data[0]  = vec_data[CordicSteps];
  assign sq_valid[0] = vec_valid[CordicSteps];

  for (genvar g = 0; g < SqrtSteps; g++) begin : g_sqrt
    gavs_sqrt_cell u_sqrt (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (sq_valid[g]),
      .data_i  (sq_data[g]),
      .valid_o (sq_valid[g+1]),
      .data_o  (sq_data[g+1])
    );
  end

  // --------------------------------------------------------------------------
  // Scaling stages between the root and the rotation
  // --------------------------------------------------------------------------
  pipe_t p1_d, p1_q, p2_d, p2_q, p3_d, p3_q, p4_d, p4_q;
  logic  p1_valid_q, p2_valid_q, p3_valid_q, p4_valid_q;
  logic [55:0] gain_prod;
  logic [62:0] lane_prod [DivLanes];
  logic [31:0] heading;
  logic [31:0] heading_ofs;
  logic [61:0] inv_prod;

  // Target speed from the distance, and dividends for the speed cap.
  always_comb begin
    p1_d      = sq_data[SqrtSteps];
    gain_prod = 56'(sq_data[SqrtSteps].sq_root) * 56'(direct_gain_q);
    p1_d.tgt  = gain_prod[55:16];
    for (int i = 0; i < DivLanes; i++) begin
      lane_prod[i]   = 63'(sq_data[SqrtSteps].dv_q[i]) * 63'(speed_limit_q);
      p1_d.dv_rem[i] = {1'b0, lane_prod[i][62:32]};
      p1_d.dv_q[i]   = lane_prod[i][31:0];
    end
  end

  // Clamp the target and find the heading relative to the yaw.
  always_comb begin
    p2_d = p1_q;
    if (p1_q.tgt > {9'd0, speed_limit_q}) begin
      p2_d.tgt = {9'd0, speed_limit_q};
    end
    heading     = p1_q.bz - {p1_q.yaw, 16'h0000};
    heading_ofs = heading + 32'h40000000;
    p2_d.flip   = heading_ofs[31];
    p2_d.rz     = heading_ofs[31] ? $signed({~heading[31], ~heading[31], heading[30:0]})
                                  : $signed({heading[31], heading});
  end

  // Remove the CORDIC gain ahead of the rotation.
  always_comb begin
    p3_d     = p2_q;
    inv_prod = 62'(p2_q.tgt[30:0]) * 62'(InvGainQ31);
    p3_d.tgt = {9'd0, inv_prod[61:31]};
  end

  // Start vector, turned by a half turn where the heading points backward.
  always_comb begin
    p4_d    = p3_q;
    p4_d.rx = p3_q.flip ? $signed(34'd0 - {3'b000, p3_q.tgt[30:0]})
                        : $signed({3'b000, p3_q.tgt[30:0]});
    p4_d.ry = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q <= 1'b0;
      p2_valid_q <= 1'b0;
      p3_valid_q <= 1'b0;
      p4_valid_q <= 1'b0;
    end else if (en) begin
      p1_valid_q <= sq_valid[SqrtSteps];
      p2_valid_q <= p1_valid_q;
      p3_valid_q <= p2_valid_q;
      p4_valid_q <= p3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_q <= p1_d;
      p2_q <= p2_d;
      p3_q <= p3_d;
      p4_q <= p4_d;
    end
  end

  // --------------------------------------------------------------------------
  // Rotation cells, then division cells
  // --------------------------------------------------------------------------
  pipe_t rot_data  [CordicSteps+1];
  logic  rot_valid [CordicSteps+1];
  pipe_t dv_data   [DivSteps+1];
  logic  dv_valid  [DivSteps+1];

  assign rot_data[0]  = p4_q;
  assign rot_valid[0] = p4_valid_q;

  for (genvar g = 0; g < CordicSteps; g++) begin : g_rot
    gavs_rot_cell #(.STEP(g)) u_rot (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (rot_valid[g]),
      .data_i  (rot_data[g]),
      .valid_o (rot_valid[g+1]),
      .data_o  (rot_data[g+1])
    );
  end

  assign dv_data[0]  = rot_data[CordicSteps];
  assign dv_valid[0] = rot_valid[CordicSteps];

  for (genvar g = 0; g < DivSteps; g++) begin : g_div
    gavs_div_cell u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (dv_valid[g]),
      .data_i  (dv_data[g]),
      .valid_o (dv_valid[g+1]),
      .data_o  (dv_data[g+1])
    );
  end

  // --------------------------------------------------------------------------
  // Result selection and output register
  // --------------------------------------------------------------------------
  function automatic logic [31:0] sat32(input logic [33:0] v);
    logic [31:0] r;
    if (v[33:31] == 3'b000 || v[33:31] == 3'b111) begin
      r = v[31:0];
    end else begin
      r = v[33] ? 32'h80000000 : 32'h7FFFFFFF;
    end
    return r;
  endfunction

  pipe_t       fin;
  logic [95:0] out_d;
  logic [95:0] out_q;
  zone_e       zone_q;
  logic [31:0] capped [DivLanes];

  assign fin = dv_data[DivSteps];

  // Pick the result that the zone calls for.
  always_comb begin
    for (int i = 0; i < DivLanes; i++) begin
      capped[i] = fin.dv_neg[i] ? (32'd0 - fin.dv_q[i]) : fin.dv_q[i];
    end
    case (fin.zone)
      ZONE_GOAL:    out_d = '0;
      ZONE_DIRECT:  out_d = {32'd0, sat32(fin.ry), sat32(fin.rx)};
      ZONE_LIMITED: out_d = fin.lim ? {capped[2], capped[1], capped[0]}
                                    : {fin.wz, fin.vy, fin.vx};
      default:      out_d = {fin.wz, fin.vy, fin.vx};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (en) begin
      m_valid_q <= dv_valid[DivSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q  <= out_d;
      zone_q <= fin.zone;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = out_q;
  assign m_axis_tuser  = zone_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `GAVS_ASSERT_IMPL(goal_zero_a, m_axis_tvalid && (m_axis_tuser == ZONE_GOAL),
    m_axis_tdata == 96'd0, "at-goal result is not zero")
  `GAVS_ASSERT_IMPL(direct_wz_a, m_axis_tvalid && (m_axis_tuser == ZONE_DIRECT),
    m_axis_tdata[95:64] == 32'd0, "direct-zone result has a yaw rate")
  `GAVS_ASSERT_NEXT(stall_hold_a, m_axis_tvalid && !m_axis_tready,
    $stable(dv_valid[DivSteps]) && $stable(fin), "chain moved during a stall")

endmodule
